// ----- sv/ncm_pkg.sv -----
// shared types, constants and helpers for the negacyclic convolution core
package ncm_pkg;

	localparam int MAX_LEN = 64;
	localparam int COEF_W  = 32;
	localparam int LEN_W   = $clog2(MAX_LEN + 1);
	localparam int IDX_W   = $clog2(MAX_LEN);
	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(MAX_LEN);

	// control that travels with each read pair into the mac unit
	typedef struct packed {
		logic             valid;
		logic             first;
		logic             fin;
		logic             neg;
		logic             last_i;
		logic [IDX_W-1:0] idx;
	} ncm_ctrl_t;

	// highest index in use for a programmed length, zero acting as one
	function automatic logic [IDX_W-1:0] eff_last(input logic [LEN_W-1:0] len);
		logic [IDX_W-1:0] r;
		if (len <= LEN_W'(1)) begin
			r = '0;
		end else if (len >= LEN_W'(MAX_LEN)) begin
			r = IDX_W'(MAX_LEN - 1);
		end else begin
			r = IDX_W'(len - LEN_W'(1));
		end
		return r;
	endfunction

endpackage

// ----- sv/ncm_mac.sv -----
// multiply-accumulate unit: product stage, signed accumulate and result register
module ncm_mac (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ncm_pkg::ncm_ctrl_t        ctrl_s1,
	input  logic [ncm_pkg::COEF_W-1:0] a_s1,
	input  logic [ncm_pkg::COEF_W-1:0] b_s1,
	output logic                      coef_valid,
	output logic [ncm_pkg::COEF_W-1:0] coef_value,
	output logic [ncm_pkg::IDX_W-1:0]  coef_index,
	output logic                      last
);
	import ncm_pkg::*;

	ncm_ctrl_t             ctrl_s2;
	logic [COEF_W-1:0]     prod_s2;
	logic [COEF_W-1:0]     prod_lo;
	logic [COEF_W-1:0]     term;
	logic [COEF_W-1:0]     sum;
	logic [COEF_W-1:0]     acc_q;
	logic                  valid_q;
	logic [COEF_W-1:0]     value_q;
	logic [IDX_W-1:0]      index_q;
	logic                  last_q;

	// product, low word only
	assign prod_lo = a_s1 * b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else begin
			ctrl_s2 <= ctrl_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= prod_lo;
	end

	// wrapped terms get negated, first term of a row restarts the sum
	assign term = ctrl_s2.neg ? (COEF_W'(0) - prod_s2) : prod_s2;
	assign sum  = (ctrl_s2.first ? COEF_W'(0) : acc_q) + term;

	always_ff @(posedge clk) begin
		if (ctrl_s2.valid) begin
			acc_q <= sum;
		end
		if (ctrl_s2.valid && ctrl_s2.fin) begin
			value_q <= sum;
			index_q <= ctrl_s2.idx;
			last_q  <= ctrl_s2.last_i;
		end
	end

	// result strobe, one cycle per coefficient
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= ctrl_s2.valid && ctrl_s2.fin;
		end
	end

	assign coef_valid = valid_q;
	assign coef_value = value_q;
	assign coef_index = index_q;
	assign last       = valid_q && last_q;

endmodule

// ----- sv/negacyclic_convolution_mod_2_32_core.sv -----
// negacyclic convolution core: operand memories, row/column sequencer and mac unit
//
//  channel   direction  handshake          words
//  operand   in         start / busy       a_coef, b_coef
//  result    out        coef_valid strobe  coef_value, coef_index, last
//  config    in         cfg_we             cfg_wdata (poly_len)
//
// Loading accepts one operand word per cycle while busy is low. The word that
// completes a pair raises busy; the core then runs n*n multiply-accumulates,
// one per cycle through the single mac unit fed by the two operand memories.
// Results come one per row of n multiply-accumulates and busy drops after the
// cycle that shows the last one. Reset clears the load count, the sequencer
// and poly_len (to 64); the memories are not cleared. The receiver cannot
// stall results.
module negacyclic_convolution_mod_2_32_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [ncm_pkg::COEF_W-1:0] a_coef,
	input  logic [ncm_pkg::COEF_W-1:0] b_coef,
	input  logic                       cfg_we,
	input  logic [ncm_pkg::LEN_W-1:0]  cfg_wdata,
	output logic                       coef_valid,
	output logic [ncm_pkg::COEF_W-1:0] coef_value,
	output logic [ncm_pkg::IDX_W-1:0]  coef_index,
	output logic                       last
);
	import ncm_pkg::*;

	logic [COEF_W-1:0] mem_a [MAX_LEN];
	logic [COEF_W-1:0] mem_b [MAX_LEN];

	logic [LEN_W-1:0] poly_len_q;
	logic [IDX_W-1:0] load_cnt_q;
	logic [IDX_W-1:0] nm1_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] j_q;
	logic [IDX_W-1:0] k_q;
	logic             neg_q;
	logic             run_q;
	logic             busy_q;

	logic             accept;
	logic             complete;
	logic [IDX_W-1:0] len_last;
	ncm_ctrl_t        ctrl_s0;
	ncm_ctrl_t        ctrl_s1;
	logic [COEF_W-1:0] a_s1;
	logic [COEF_W-1:0] b_s1;

	assign accept   = start && !busy_q;
	assign len_last = eff_last(poly_len_q);
	assign complete = accept && (load_cnt_q >= len_last);
	assign busy     = busy_q;

	// length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_len_q <= LEN_RESET;
		end else if (cfg_we) begin
			poly_len_q <= cfg_wdata;
		end
	end

	// operand memories: one write port for loading, one read port each
	always_ff @(posedge clk) begin
		if (accept) begin
			mem_a[load_cnt_q] <= a_coef;
			mem_b[load_cnt_q] <= b_coef;
		end
		a_s1 <= mem_a[j_q];
		b_s1 <= mem_b[k_q];
	end

	// load counter and row/column sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
			nm1_q      <= '0;
			i_q        <= '0;
			j_q        <= '0;
			k_q        <= '0;
			neg_q      <= 1'b0;
			run_q      <= 1'b0;
			busy_q     <= 1'b0;
		end else begin
			if (accept) begin
				load_cnt_q <= complete ? '0 : load_cnt_q + IDX_W'(1);
			end
			if (complete) begin
				busy_q <= 1'b1;
				run_q  <= 1'b1;
				nm1_q  <= len_last;
				i_q    <= '0;
				j_q    <= '0;
				k_q    <= '0;
				neg_q  <= 1'b0;
			end else if (run_q) begin
				if (j_q == nm1_q) begin
					if (i_q == nm1_q) begin
						run_q <= 1'b0;
					end else begin
						i_q   <= i_q + IDX_W'(1);
						j_q   <= '0;
						k_q   <= i_q + IDX_W'(1);
						neg_q <= 1'b0;
					end
				end else begin
					j_q <= j_q + IDX_W'(1);
					// b index walks down and wraps to n-1, terms past the wrap are negated
					if (k_q == '0) begin
						k_q   <= nm1_q;
						neg_q <= 1'b1;
					end else begin
						k_q <= k_q - IDX_W'(1);
					end
				end
			end
			if (coef_valid && last) begin
				busy_q <= 1'b0;
			end
		end
	end

	// control for the pair being read this cycle
	always_comb begin
		ctrl_s0.valid  = run_q;
		ctrl_s0.first  = (j_q == '0);
		ctrl_s0.fin    = (j_q == nm1_q);
		ctrl_s0.neg    = neg_q;
		ctrl_s0.last_i = (i_q == nm1_q);
		ctrl_s0.idx    = i_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1 <= ctrl_s0;
		end
	end

	ncm_mac u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl_s1    (ctrl_s1),
		.a_s1       (a_s1),
		.b_s1       (b_s1),
		.coef_valid (coef_valid),
		.coef_value (coef_value),
		.coef_index (coef_index),
		.last       (last)
	);

endmodule

// ----- sv/ncm_checker.sv -----
// port-level checks on the negacyclic convolution core and their bind
module ncm_checker (
	input logic clk,
	input logic arst_n,
	input logic busy,
	input logic coef_valid,
	input logic last
);

	// results only appear while a pair is being worked on
	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		coef_valid |-> busy) else $error("result word outside busy");

	// result words are never back to back
	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		coef_valid |=> !coef_valid) else $error("result words back to back");

	// the last word of a pair frees the core
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		coef_valid && last |=> !busy) else $error("busy held after last word");

	// busy drops only after the last word
	a_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(coef_valid && last)) else $error("busy dropped early");

endmodule

bind negacyclic_convolution_mod_2_32_core ncm_checker u_ncm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.busy       (busy),
	.coef_valid (coef_valid),
	.last       (last)
);
